// File: rtl/xfr_pkg.sv
// xfr_pkg: shared types and constants of the xor frame receiver
// depends on nothing; used by the interface, the stages and the top level

package xfr_pkg;

  // size of the downstream data buffer, caps the accepted frame length
  localparam logic [7:0] MaxDataLen = 8'd16;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_START_BYTE = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_DATA = 1'b0,
    KIND_EOF  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CSUM    = 2'd1,
    STATUS_LEN_ERR = 2'd2
  } status_e;

  // parser states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_COMMAND  = 6'b000010,
    ST_LENGTH   = 6'b000100,
    ST_DATA     = 6'b001000,
    ST_CHECKSUM = 6'b010000,
    ST_ABORT    = 6'b100000
  } parse_state_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_index;
    logic [7:0] data_byte;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    status_e    status;
  } result_t;

  // live configuration seen by the parser
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] max_length;
  } cfg_t;

endpackage

// File: rtl/xfr_stream_if.sv
// xfr_stream_if: valid/ready channel with a typed payload
// depends on xfr_pkg for the default payload type

interface xfr_stream_if #(
  parameter type payload_t = xfr_pkg::rx_item_t
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/xfr_in_stage.sv
// xfr_in_stage: input register for received bytes, full rate while downstream is ready
// depends on xfr_pkg and xfr_stream_if

module xfr_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  xfr_stream_if.sink    up,
  xfr_stream_if.source  dn
);

  logic                valid_q;
  xfr_pkg::rx_item_t   item_q;

  assign up.ready   = !valid_q || dn.ready;
  assign dn.valid   = valid_q;
  assign dn.payload = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up.ready) begin
      valid_q <= up.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up.valid && up.ready) begin
      item_q <= up.payload;
    end
  end

endmodule

// File: rtl/xfr_parser.sv
// xfr_parser: frame state machine, running xor and result register
// depends on xfr_pkg and xfr_stream_if

module xfr_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  xfr_pkg::cfg_t cfg_i,
  xfr_stream_if.sink    in,
  xfr_stream_if.source  out
);

  xfr_pkg::parse_state_e state_q, state_d;
  logic [7:0]            xor_q, xor_d;
  logic [7:0]            count_q, count_d;
  logic [7:0]            cmd_q, cmd_d;
  logic [7:0]            len_q, len_d;

  logic                  out_valid_q;
  xfr_pkg::result_t      res_q, res_d;
  logic                  emit;
  logic                  fire;
  logic [7:0]            b;
  logic [7:0]            limit;
  logic [7:0]            count_inc;

  assign b         = in.payload.rx_byte;
  assign in.ready  = !out_valid_q || out.ready;
  assign fire      = in.valid && in.ready;
  assign limit     = (cfg_i.max_length > xfr_pkg::MaxDataLen) ? xfr_pkg::MaxDataLen
                                                              : cfg_i.max_length;
  assign count_inc = count_q + 8'd1;

  always_comb begin
    state_d = state_q;
    xor_d   = xor_q;
    count_d = count_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    emit    = 1'b0;
    res_d.kind       = xfr_pkg::KIND_EOF;
    res_d.data_index = 8'd0;
    res_d.data_byte  = 8'd0;
    res_d.status     = xfr_pkg::STATUS_OK;
    case (state_q)
      xfr_pkg::ST_COMMAND: begin
        cmd_d   = b;
        xor_d   = xor_q ^ b;
        state_d = xfr_pkg::ST_LENGTH;
      end
      xfr_pkg::ST_LENGTH: begin
        len_d   = b;
        xor_d   = xor_q ^ b;
        count_d = 8'd0;
        if (b > limit) begin
          state_d      = xfr_pkg::ST_ABORT;
          emit         = 1'b1;
          res_d.status = xfr_pkg::STATUS_LEN_ERR;
        end else if (b == 8'd0) begin
          state_d = xfr_pkg::ST_CHECKSUM;
        end else begin
          state_d = xfr_pkg::ST_DATA;
        end
      end
      xfr_pkg::ST_DATA: begin
        xor_d   = xor_q ^ b;
        count_d = count_inc;
        if (count_inc >= len_q) begin
          state_d = xfr_pkg::ST_CHECKSUM;
        end
        emit             = 1'b1;
        res_d.kind       = xfr_pkg::KIND_DATA;
        res_d.data_index = count_q;
        res_d.data_byte  = b;
      end
      xfr_pkg::ST_CHECKSUM: begin
        state_d      = xfr_pkg::ST_IDLE;
        emit         = 1'b1;
        res_d.status = (b == xor_q) ? xfr_pkg::STATUS_OK : xfr_pkg::STATUS_CSUM;
      end
      default: begin
        // idle, abort and stray codes hunt for a start byte
        if (b == cfg_i.start_byte) begin
          xor_d   = b;
          count_d = 8'd0;
          state_d = xfr_pkg::ST_COMMAND;
        end else if (state_q != xfr_pkg::ST_ABORT) begin
          state_d = xfr_pkg::ST_IDLE;
        end
      end
    endcase
    res_d.frame_command = cmd_d;
    res_d.frame_length  = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xfr_pkg::ST_IDLE;
      xor_q       <= 8'd0;
      count_q     <= 8'd0;
      cmd_q       <= 8'd0;
      len_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q     <= state_d;
        xor_q       <= xor_d;
        count_q     <= count_d;
        cmd_q       <= cmd_d;
        len_q       <= len_d;
        out_valid_q <= emit;
      end else if (out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_q <= res_d;
    end
  end

  assign out.valid   = out_valid_q;
  assign out.payload = res_q;

endmodule

// File: rtl/xor_frame_receiver.sv
// xor_frame_receiver: top level of the serial frame parser with xor checksum
// depends on xfr_pkg, xfr_stream_if, xfr_in_stage and xfr_parser

// channel  | dir | handshake            | payload
// ---------+-----+----------------------+--------------------------------------------
// rx       | in  | valid/ready          | rx_byte
// res      | out | valid/ready          | kind, data_index, data_byte, frame_command,
//          |     |                      | frame_length, status
// cfg      | in  | cfg_we_i, no ready   | cfg_idx_i selects start_byte or max_length
//
// one byte is taken every cycle while no stalled result holds the parser; a result passes
// through the input register, then the parser's result register
// bytes that give no result (start, command, accepted length, dropped bytes) still pass
// through the input register but leave the result register untouched
// a stalled result holds the parser; the input register still takes one more byte if empty
// reset clears state to idle, the running xor and counters, and loads the
// configuration defaults (start byte 0xaa, max length 16)

module xor_frame_receiver (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [7:0]   cfg_data_i,
  xfr_stream_if.sink   rx,
  xfr_stream_if.source res
);

  // configuration registers
  xfr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= 8'd170;
      cfg_q.max_length <= xfr_pkg::MaxDataLen;
    end else if (cfg_we_i) begin
      case (xfr_pkg::cfg_idx_e'(cfg_idx_i))
        xfr_pkg::CFG_START_BYTE: cfg_q.start_byte <= cfg_data_i;
        xfr_pkg::CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // registered byte between the input stage and the parser
  xfr_stream_if #(.payload_t(xfr_pkg::rx_item_t)) rx_q ();

  xfr_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .up     (rx),
    .dn     (rx_q)
  );

  xfr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in     (rx_q),
    .out    (res)
  );

endmodule

// File: tb/xor_frame_receiver_tb.sv
// xor_frame_receiver_tb: self-checking testbench of the xor frame receiver
// streams serial bytes into rx, predicts data and end-of-frame items, checks them on res
// depends on xfr_pkg, xfr_stream_if and the xor_frame_receiver rtl

module xor_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // how the trailing checksum byte of a generated frame is formed
  typedef enum int {
    CSUM_NONE,
    CSUM_GOOD,
    CSUM_BAD
  } csum_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  xfr_stream_if rx_if ();
  xfr_stream_if #(.payload_t(xfr_pkg::result_t)) res_if ();

  xor_frame_receiver u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .rx        (rx_if),
    .res       (res_if)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the configuration, updated when a write is sampled
  logic [7:0]   cfg_start = 8'hAA;
  logic [7:0]   cfg_max = xfr_pkg::MaxDataLen;

  // predictor copy of the parser state
  xfr_pkg::parse_state_e prs_state = xfr_pkg::ST_IDLE;
  logic [7:0]   csum_acc = '0;
  logic [7:0]   data_cnt = '0;
  logic [7:0]   held_cmd = '0;
  logic [7:0]   held_len = '0;

  // predicted items still waiting to come out of res, oldest first
  xfr_pkg::result_t frame_results_q[$];

  int unsigned  mismatch_cnt = 0;
  int unsigned  frame_items = 0;
  int unsigned  n_data_items = 0;
  int unsigned  n_eof_ok = 0;
  int unsigned  n_eof_csum = 0;
  int unsigned  n_eof_len = 0;

  // per-side idling switches, turned off for back-to-back stretches
  bit           rx_idle_en = 1'b1;
  bit           res_idle_en = 1'b1;

  // the parser caps the length at the data buffer size
  function automatic logic [7:0] accepted_max_len();
    return (cfg_max > xfr_pkg::MaxDataLen) ? xfr_pkg::MaxDataLen : cfg_max;
  endfunction

  // advance the predicted parser by one received byte, queue any item it emits
  function automatic void parse_rx_byte(input logic [7:0] b);
    xfr_pkg::result_t r;
    bit               has_result;
    r = '0;
    has_result = 1'b0;
    case (prs_state)
      xfr_pkg::ST_COMMAND: begin
        held_cmd = b;
        csum_acc ^= b;
        prs_state = xfr_pkg::ST_LENGTH;
      end
      xfr_pkg::ST_LENGTH: begin
        held_len = b;
        csum_acc ^= b;
        data_cnt = '0;
        if (b > accepted_max_len()) begin
          // length error ends the frame on the length byte itself
          prs_state = xfr_pkg::ST_ABORT;
          r.kind = xfr_pkg::KIND_EOF;
          r.status = xfr_pkg::STATUS_LEN_ERR;
          has_result = 1'b1;
        end else begin
          prs_state = (b == 8'd0) ? xfr_pkg::ST_CHECKSUM : xfr_pkg::ST_DATA;
        end
      end
      xfr_pkg::ST_DATA: begin
        r.kind = xfr_pkg::KIND_DATA;
        r.data_index = data_cnt;
        r.data_byte = b;
        r.status = xfr_pkg::STATUS_OK;
        csum_acc ^= b;
        data_cnt += 8'd1;
        if (data_cnt >= held_len) prs_state = xfr_pkg::ST_CHECKSUM;
        has_result = 1'b1;
      end
      xfr_pkg::ST_CHECKSUM: begin
        prs_state = xfr_pkg::ST_IDLE;
        r.kind = xfr_pkg::KIND_EOF;
        r.status = (b == csum_acc) ? xfr_pkg::STATUS_OK : xfr_pkg::STATUS_CSUM;
        has_result = 1'b1;
      end
      default: begin
        // idle and abort wait for the start byte, abort stays sticky otherwise
        if (b == cfg_start) begin
          csum_acc = b;
          data_cnt = '0;
          prs_state = xfr_pkg::ST_COMMAND;
        end else if (prs_state != xfr_pkg::ST_ABORT) begin
          prs_state = xfr_pkg::ST_IDLE;
        end
      end
    endcase
    if (has_result) begin
      r.frame_command = held_cmd;
      r.frame_length = held_len;
      frame_results_q.push_back(r);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_result(input xfr_pkg::result_t got);
    xfr_pkg::result_t want;
    if (frame_results_q.size() == 0) begin
      mismatch_cnt++;
      $display("%0t: unexpected item, expected none, actual %p", $time, got);
    end else begin
      want = frame_results_q.pop_front();
      compare_field("kind", 8'(want.kind), 8'(got.kind));
      compare_field("data_index", want.data_index, got.data_index);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("frame_command", want.frame_command, got.frame_command);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("status", 8'(want.status), 8'(got.status));
      if (want.kind == xfr_pkg::KIND_DATA) n_data_items++;
      else if (want.status == xfr_pkg::STATUS_OK) n_eof_ok++;
      else if (want.status == xfr_pkg::STATUS_CSUM) n_eof_csum++;
      else n_eof_len++;
    end
  endfunction

  // sample config writes, accepted rx bytes and accepted res items at each edge;
  // everything read here is the value from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (xfr_pkg::cfg_idx_e'(cfg_idx_i))
          xfr_pkg::CFG_START_BYTE: cfg_start = cfg_data_i;
          xfr_pkg::CFG_MAX_LENGTH: cfg_max = cfg_data_i;
          default: ;
        endcase
      end
      if (rx_if.valid && rx_if.ready) parse_rx_byte(rx_if.payload.rx_byte);
      if (res_if.valid && res_if.ready) check_result(res_if.payload);
    end
  end

  // res sink: per item a random stall when idling is on, then ready until taken
  initial begin : res_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = res_idle_en ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // send one byte on rx after a random gap; returns at the edge that took it
  // valid stays high when the next byte follows with no gap
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = rx_idle_en ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.payload.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
  endtask

  // start, command, length, n_data payload bytes, then an optional checksum;
  // fill below zero means random payload bytes
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input int unsigned n_data, input csum_mode_e mode,
                            input int fill = -1);
    logic [7:0] sum;
    logic [7:0] d;
    sum = cfg_start ^ cmd ^ len;
    send_byte(cfg_start);
    send_byte(cmd);
    send_byte(len);
    for (int i = 0; i < n_data; i++) begin
      d = (fill < 0) ? 8'($urandom) : fill[7:0];
      sum ^= d;
      send_byte(d);
    end
    // flip one bit so a bad checksum never matches by chance
    if (mode == CSUM_BAD) sum ^= 8'h01 << $urandom_range(0, 7);
    if (mode != CSUM_NONE) send_byte(sum);
    frame_items += 3 + n_data + ((mode != CSUM_NONE) ? 1 : 0);
  endtask

  task automatic send_noise(input int unsigned n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom));
  endtask

  // hold rx, wait for every predicted item, then let the pipe settle
  // (bytes with no item may still sit in the input register)
  task automatic wait_results_drained();
    rx_if.valid <= 1'b0;
    do @(posedge clk_i); while (frame_results_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // both registers in consecutive cycles, only while the parser is quiet
  task automatic set_config(input logic [7:0] start_val, input logic [7:0] max_val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= xfr_pkg::CFG_START_BYTE;
    cfg_data_i <= start_val;
    @(posedge clk_i);
    cfg_idx_i <= xfr_pkg::CFG_MAX_LENGTH;
    cfg_data_i <= max_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly well-formed frames with random content, plus length errors,
  // cut-off frames and stray bytes; stops once at least n frame bytes are sent
  task automatic send_mixed_traffic(input int unsigned n);
    int unsigned goal;
    int unsigned pick;
    logic [7:0]  lim;
    logic [7:0]  len;
    goal = frame_items + n;
    while (frame_items < goal) begin
      lim = accepted_max_len();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = 8'($urandom_range(0, lim));
        send_frame(8'($urandom), len, len,
                   ($urandom_range(0, 6) == 0) ? CSUM_BAD : CSUM_GOOD);
      end else if (pick < 80) begin
        // too long, then zero to three bytes that the abort state drops unless one is a start byte
        len = 8'($urandom_range(lim + 1, 255));
        send_frame(8'($urandom), len, 0, CSUM_NONE);
        send_noise($urandom_range(0, 3));
      end else if (pick < 90 && lim != 0) begin
        // cut short, the next start byte lands in the data phase
        len = 8'($urandom_range(1, lim));
        send_frame(8'($urandom), len, $urandom_range(0, len - 1), CSUM_NONE);
      end else begin
        send_noise($urandom_range(1, 4));
      end
    end
  endtask

  // default config: idle drops, zero length, bad checksum, length error and recovery
  task automatic test_frame_basics();
    send_noise(0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_frame(8'hFF, 8'd0, 0, CSUM_GOOD);
    send_frame(8'h00, 8'd1, 1, CSUM_BAD, 8'h00);
    send_frame(8'h5A, 8'd17, 0, CSUM_NONE);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_frame(8'h81, 8'd0, 0, CSUM_GOOD);
  endtask

  // register extremes: longest accepted frame and first rejected length per setting
  task automatic test_length_limits();
    logic [7:0] starts [5] = '{8'h00, 8'hFF, 8'h7E, 8'h55, 8'hAA};
    logic [7:0] maxes  [5] = '{8'd0, 8'd255, 8'd1, 8'd17, 8'd16};
    logic [7:0] lim;
    for (int i = 0; i < 5; i++) begin
      wait_results_drained();
      set_config(starts[i], maxes[i]);
      lim = accepted_max_len();
      send_frame(8'h00, lim, lim, CSUM_GOOD, 8'hFF);
      send_frame(8'hFF, lim + 8'd1, 0, CSUM_NONE);
      if (i == 1) send_frame(8'h3C, 8'd255, 0, CSUM_NONE);
    end
  endtask

  // random phases, each with its own config and idling mix
  task automatic test_random_frames();
    for (int p = 0; p < 5; p++) begin
      wait_results_drained();
      set_config((p == 0) ? 8'hAA : 8'($urandom),
                 ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 20)) : 8'($urandom));
      rx_idle_en = ($urandom_range(0, 3) != 0);
      res_idle_en = ($urandom_range(0, 3) != 0);
      send_mixed_traffic(160);
    end
  endtask

  // sender holds off mid-stream until the result side has caught up
  task automatic test_pause_until_drained();
    rx_idle_en = 1'b1;
    res_idle_en = 1'b1;
    send_mixed_traffic(60);
    wait_results_drained();
    send_mixed_traffic(60);
  endtask

  // full rate in, then full rate in against a stalling sink
  task automatic test_back_to_back();
    rx_idle_en = 1'b0;
    res_idle_en = 1'b0;
    send_mixed_traffic(100);
    res_idle_en = 1'b1;
    send_mixed_traffic(60);
    rx_idle_en = 1'b1;
  endtask

  initial begin : main
    int unsigned drain_cycles;
    rx_if.valid <= 1'b0;
    rx_if.payload <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= xfr_pkg::CFG_START_BYTE;
    cfg_data_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_basics();
    test_length_limits();
    test_random_frames();
    test_pause_until_drained();
    test_back_to_back();

    // let the tail drain, bounded
    rx_if.valid <= 1'b0;
    drain_cycles = 0;
    while (frame_results_q.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (frame_results_q.size() != 0) begin
      mismatch_cnt++;
      $display("%0t: expected %0d more items, actual 0", $time, frame_results_q.size());
    end

    $display("covered %0d frame bytes: %0d data items, %0d good frame ends,",
             frame_items, n_data_items, n_eof_ok);
    $display("%0d checksum failures and %0d length errors", n_eof_csum, n_eof_len);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/xfr_pkg.sv
rtl/xfr_stream_if.sv
rtl/xfr_in_stage.sv
rtl/xfr_parser.sv
rtl/xor_frame_receiver.sv
tb/xor_frame_receiver_tb.sv
